// ===== rtl/lbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpr_pkg
// Shared types and constants of the radius local binary pattern block.
// ----------------------------------------------------------------------------
package lbpr_pkg;

  localparam int PIXEL_W      = 16;
  localparam int CODE_W       = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS       = 2'd2;

  localparam int BIT_TOP          = 7;
  localparam int BIT_TOP_LEFT     = 6;
  localparam int BIT_LEFT         = 5;
  localparam int BIT_BOTTOM_LEFT  = 4;
  localparam int BIT_BOTTOM       = 3;
  localparam int BIT_BOTTOM_RIGHT = 2;
  localparam int BIT_RIGHT        = 1;
  localparam int BIT_TOP_RIGHT    = 0;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CODE_W-1:0]  code_t;

  typedef struct packed {
    logic rd_en;
    logic commit;
  } ls_ctrl_t;

endpackage

// ===== rtl/lbpr_line_store.sv =====
// ----------------------------------------------------------------------------
// lbpr_line_store
// Column-organized line memory, one lane per stored row, read-modify-write
// of one column per request with forwarding of the last written column.
// ----------------------------------------------------------------------------
module lbpr_line_store
  import lbpr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int LANES = 8,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int LANE_W = $clog2(LANES),
  localparam int WORD_W = LANES * PIXEL_W
) (
  input  logic              clk,
  input  logic              rst,
  input  ls_ctrl_t          ctrl,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [LANE_W-1:0] top_lane,
  input  logic [LANE_W-1:0] mid_lane,
  input  pixel_t            wr_pixel,
  output pixel_t            top_pixel,
  output pixel_t            mid_pixel
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] fwd_word;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] wr_word;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] fwd_addr;
  logic              fwd_valid;

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[rd_addr];
      addr  <= rd_addr;
    end
    if (ctrl.commit) begin
      mem[addr] <= wr_word;
      fwd_word  <= wr_word;
      fwd_addr  <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ctrl.commit) begin
      fwd_valid <= 1'b1;
    end
  end

  // latest write wins over the registered read of the same column
  always_comb begin
    word = (fwd_valid && fwd_addr == addr) ? fwd_word : rdata;
    wr_word = word;
    wr_word[top_lane*PIXEL_W +: PIXEL_W] = wr_pixel;
    top_pixel = word[top_lane*PIXEL_W +: PIXEL_W];
    mid_pixel = word[mid_lane*PIXEL_W +: PIXEL_W];
  end

endmodule

// ===== rtl/lbpr_window.sv =====
// ----------------------------------------------------------------------------
// lbpr_window
// Short column histories of the top, middle and current rows and the eight
// neighbour compares that form the pattern code.
// ----------------------------------------------------------------------------
module lbpr_window
  import lbpr_pkg::*;
#(
  parameter int MAX_RADIUS = 4,
  localparam int SPAN_MAX = 2 * MAX_RADIUS,
  localparam int RAD_W    = $clog2(MAX_RADIUS + 1),
  localparam int SLOT_W   = $clog2(SPAN_MAX)
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [RAD_W-1:0] radius,
  input  pixel_t           top_pixel,
  input  pixel_t           mid_pixel,
  input  pixel_t           cur_pixel,
  output code_t            code
);

  pixel_t            top_line [SPAN_MAX];
  pixel_t            mid_line [SPAN_MAX];
  pixel_t            cur_line [SPAN_MAX];
  logic [SLOT_W-1:0] near;
  logic [SLOT_W-1:0] far;
  pixel_t            centre;

  always_ff @(posedge clk) begin
    if (shift) begin
      top_line[0] <= top_pixel;
      mid_line[0] <= mid_pixel;
      cur_line[0] <= cur_pixel;
      for (int k = 1; k < SPAN_MAX; k++) begin
        top_line[k] <= top_line[k-1];
        mid_line[k] <= mid_line[k-1];
        cur_line[k] <= cur_line[k-1];
      end
    end
  end

  // entry k holds the column k+1 places to the left
  always_comb begin
    near   = SLOT_W'(32'(radius) - 32'd1);
    far    = SLOT_W'((32'(radius) << 1) - 32'd1);
    centre = mid_line[near];
    code   = '0;
    code[BIT_TOP]          = top_line[near] > centre;
    code[BIT_TOP_LEFT]     = top_line[far] > centre;
    code[BIT_LEFT]         = mid_line[far] > centre;
    code[BIT_BOTTOM_LEFT]  = cur_line[far] > centre;
    code[BIT_BOTTOM]       = cur_line[near] > centre;
    code[BIT_BOTTOM_RIGHT] = cur_pixel > centre;
    code[BIT_RIGHT]        = mid_pixel > centre;
    code[BIT_TOP_RIGHT]    = top_pixel > centre;
  end

endmodule

// ===== rtl/local_binary_pattern_radius.sv =====
// ----------------------------------------------------------------------------
// local_binary_pattern_radius
// A centre's result follows its last pixel request through stage s1 and the
// output register. Throughput: one request per cycle while pixel_stall is low;
// each pixel reads and writes back its line store column, one port each.
// Reset clears counters and pipeline valids and loads register defaults; the
// line store and histories hold no defined data and need no clearing pass.
// ----------------------------------------------------------------------------
module local_binary_pattern_radius
  import lbpr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 4,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output code_t                  code,
  output logic [ROW_W-1:0]       center_row,
  output logic [COL_W-1:0]       center_col
);

  localparam int SPAN_MAX     = 2 * MAX_RADIUS;
  localparam int RAD_W        = $clog2(MAX_RADIUS + 1);
  localparam int SPAN_W       = RAD_W + 1;
  localparam int SUM_W        = SPAN_W + 1;
  localparam int SLOT_W       = $clog2(SPAN_MAX);
  localparam int WIDTH_RESET  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_RESET = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;

  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_last;
  logic [RAD_W-1:0]  radius;
  logic [SPAN_W-1:0] span;

  logic [31:0] width_in;
  logic [31:0] height_in;
  logic [31:0] radius_in;
  logic [31:0] width_clamped;
  logic [31:0] height_clamped;
  logic [31:0] radius_clamped;
  logic        cfg_restart;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  slot_sum;
  logic [SLOT_W-1:0] mid_slot_next;
  logic              emit_next;
  logic              col_end;
  logic              frame_end;
  logic              slot_wrap;

  logic              s1_valid;
  pixel_t            s1_pixel;
  logic              s1_emit;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [SLOT_W-1:0] s1_slot;
  logic [SLOT_W-1:0] s1_mid_slot;

  logic     hold;
  logic     accept;
  logic     advance;
  ls_ctrl_t ls_ctrl;
  pixel_t   top_pixel;
  pixel_t   mid_pixel;
  code_t    code_next;

  // configuration with range clamping
  always_comb begin
    width_in  = 32'(cfg_data[WIDTH_REG_W-1:0]);
    height_in = 32'(cfg_data[HEIGHT_REG_W-1:0]);
    radius_in = 32'(cfg_data[RADIUS_REG_W-1:0]);
    width_clamped  = (width_in == 32'd0) ? 32'd1 :
                     (width_in > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : width_in;
    height_clamped = (height_in == 32'd0) ? 32'd1 :
                     (height_in > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : height_in;
    radius_clamped = (radius_in == 32'd0) ? 32'd1 :
                     (radius_in > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS) : radius_in;
    cfg_restart = cfg_write && (cfg_index == CFG_IMAGE_WIDTH ||
                                cfg_index == CFG_IMAGE_HEIGHT ||
                                cfg_index == CFG_RADIUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= COL_W'(WIDTH_RESET - 1);
      row_last <= ROW_W'(HEIGHT_RESET - 1);
      radius   <= RAD_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  col_last <= COL_W'(width_clamped - 32'd1);
        CFG_IMAGE_HEIGHT: row_last <= ROW_W'(height_clamped - 32'd1);
        CFG_RADIUS:       radius   <= RAD_W'(radius_clamped);
        default: ;
      endcase
    end
  end

  assign span = {radius, 1'b0};

  // position of the next pixel
  always_comb begin
    slot_sum      = SUM_W'(slot) + SUM_W'(radius);
    mid_slot_next = (slot_sum >= SUM_W'(span)) ? SLOT_W'(slot_sum - SUM_W'(span))
                                                : SLOT_W'(slot_sum);
    emit_next     = (32'(row) >= 32'(span)) && (32'(col) >= 32'(span));
    col_end       = col >= col_last;
    frame_end     = row >= row_last;
    slot_wrap     = (SUM_W'(slot) + SUM_W'(1)) >= SUM_W'(span);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (cfg_restart) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        if (frame_end) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + ROW_W'(1);
          slot <= slot_wrap ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // handshake
  always_comb begin
    hold        = s1_valid && s1_emit && result_valid && result_stall;
    pixel_stall = hold;
    accept      = pixel_valid && !hold;
    advance     = s1_valid && !hold;
    ls_ctrl.rd_en  = accept;
    ls_ctrl.commit = advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pixel;
      s1_emit     <= emit_next;
      s1_row      <= ROW_W'(32'(row) - 32'(radius));
      s1_col      <= COL_W'(32'(col) - 32'(radius));
      s1_slot     <= slot;
      s1_mid_slot <= mid_slot_next;
    end
  end

  lbpr_line_store #(
    .DEPTH (MAX_WIDTH),
    .LANES (SPAN_MAX)
  ) u_line_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ls_ctrl),
    .rd_addr   (col),
    .top_lane  (s1_slot),
    .mid_lane  (s1_mid_slot),
    .wr_pixel  (s1_pixel),
    .top_pixel (top_pixel),
    .mid_pixel (mid_pixel)
  );

  lbpr_window #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk       (clk),
    .shift     (advance),
    .radius    (radius),
    .top_pixel (top_pixel),
    .mid_pixel (mid_pixel),
    .cur_pixel (s1_pixel),
    .code      (code_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      code       <= code_next;
      center_row <= s1_row;
      center_col <= s1_col;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid && result_valid)
    else $error("pixel stall with a free pipeline");

  a_slot_in_span: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(slot) < SUM_W'(span))
    else $error("row slot outside the line span");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    col <= col_last)
    else $error("column count past the row end");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_restart |=> col == '0 && row == '0 && slot == '0)
    else $error("register write did not restart the frame");

endmodule
